/* rtl/core/sparse_matrix_coo_table_macros.svh */
// assertion macros used by the coordinate table datapath
`ifndef SPARSE_MATRIX_COO_TABLE_MACROS_SVH
`define SPARSE_MATRIX_COO_TABLE_MACROS_SVH

// clocked check, held off while reset is high
`define SMCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication check, held off while reset is high
`define SMCT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/smct_pkg.sv */
// types and constants of the coordinate table
package smct_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_LOOKUP  = 2'd1,
    CMD_ROW_SUM = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_ZERO  = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  localparam int CfgIndexW = 8;
  localparam int CfgDataW  = 16;
  localparam logic [CfgIndexW-1:0] CFG_NUM_ROWS = 8'd0;
  localparam logic [CfgIndexW-1:0] CFG_NUM_COLS = 8'd1;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic scan_start;
    logic scan_rd;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic skip_scan;
    logic scan_last;
    logic out_free;
  } ctrl_status_t;

endpackage

/* rtl/core/smct_if.sv */
// command and result channels of the coordinate table
interface smct_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [15:0]        row;
  logic [15:0]        col;
  logic signed [31:0] value;

  modport source (output valid, command, row, col, value, input ready);
  modport sink (input valid, command, row, col, value, output ready);
endinterface

interface smct_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [6:0]         entry_count;
  logic [1:0]         status;

  modport source (output valid, result_value, entry_count, status, input ready);
  modport sink (input valid, result_value, entry_count, status, output ready);
endinterface

/* rtl/core/smct_ctrl.sv */
// sequencer for accept, scan and finish of one command
module smct_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  smct_pkg::ctrl_status_t  sts,
  output smct_pkg::ctrl_cmd_t     cmd
);

  smct_pkg::state_t state;
  smct_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smct_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      smct_pkg::ST_IDLE: begin
        if (sts.in_valid) state_next = smct_pkg::ST_EVAL;
      end
      smct_pkg::ST_EVAL: begin
        state_next = sts.skip_scan ? smct_pkg::ST_FINISH : smct_pkg::ST_SCAN;
      end
      smct_pkg::ST_SCAN: begin
        if (sts.scan_last) state_next = smct_pkg::ST_DRAIN;
      end
      smct_pkg::ST_DRAIN: begin
        state_next = smct_pkg::ST_FINISH;
      end
      smct_pkg::ST_FINISH: begin
        if (sts.out_free) state_next = smct_pkg::ST_IDLE;
      end
      default: begin
        state_next = smct_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      smct_pkg::ST_IDLE:   cmd.in_ready = 1'b1;
      smct_pkg::ST_EVAL:   cmd.scan_start = 1'b1;
      smct_pkg::ST_SCAN:   cmd.scan_rd = 1'b1;
      smct_pkg::ST_DRAIN:  cmd = '0;
      smct_pkg::ST_FINISH: cmd.finish = sts.out_free;
      default:             cmd = '0;
    endcase
  end

endmodule

/* rtl/core/smct_datapath.sv */
// entry memory, scan compare, row accumulator and result register
`include "sparse_matrix_coo_table_macros.svh"

module smct_datapath #(
  parameter int CAPACITY = 64,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [smct_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [smct_pkg::CfgDataW-1:0]  cfg_data,
  smct_in_if.sink                        items,
  smct_out_if.source                     results,
  input  smct_pkg::ctrl_cmd_t            cmd,
  output smct_pkg::ctrl_status_t         sts
);

  localparam logic [CW-1:0] Cap = CW'(CAPACITY);

  logic [15:0] num_rows;
  logic [15:0] num_cols;

  // latched command beat
  logic [1:0]  cmd_q;
  logic [15:0] row_q;
  logic [15:0] col_q;
  logic [31:0] val_q;

  // entry memory, filled in slot order, so slots below count are the valid ones
  logic [63:0] mem [CAPACITY];
  logic [63:0] rd_data;
  logic        rd_valid;
  logic [AW-1:0] rd_idx;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] idx;

  logic          hit;
  logic [AW-1:0] hit_idx;
  logic [31:0]   hit_val;
  logic [31:0]   acc;

  logic          wr_en;
  logic [AW-1:0] wr_addr;

  logic          row_ok;
  logic          col_ok;
  smct_pkg::status_t pre_status;
  smct_pkg::status_t fin_status;
  logic          known_cmd;
  logic [31:0]   fin_value;

  logic          out_valid;
  logic [31:0]   out_value;
  logic [6:0]    out_count;
  smct_pkg::status_t out_status;
  logic [31:0]   count_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= 16'd1;
      num_cols <= 16'd1;
    end else if (cfg_we) begin
      if (cfg_index == smct_pkg::CFG_NUM_ROWS) num_rows <= cfg_data;
      if (cfg_index == smct_pkg::CFG_NUM_COLS) num_cols <= cfg_data;
    end
  end

  // no beat is taken while reset is high
  assign items.ready = cmd.in_ready && !rst;

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      cmd_q <= items.command;
      row_q <= items.row;
      col_q <= items.col;
      val_q <= items.value;
    end
  end

  assign row_ok = (row_q != 16'd0) && (row_q <= num_rows);
  assign col_ok = (col_q != 16'd0) && (col_q <= num_cols);

  always_comb begin
    pre_status = smct_pkg::STAT_OK;
    known_cmd  = 1'b1;
    case (cmd_q)
      smct_pkg::CMD_INSERT: begin
        if (!row_ok || !col_ok) pre_status = smct_pkg::STAT_RANGE;
        else if (val_q == 32'd0) pre_status = smct_pkg::STAT_ZERO;
      end
      smct_pkg::CMD_LOOKUP: begin
        if (!row_ok || !col_ok) pre_status = smct_pkg::STAT_RANGE;
      end
      smct_pkg::CMD_ROW_SUM: begin
        if (!row_ok) pre_status = smct_pkg::STAT_RANGE;
      end
      default: known_cmd = 1'b0;
    endcase
  end

  assign sts.in_valid  = items.valid;
  assign sts.skip_scan = (pre_status != smct_pkg::STAT_OK) || !known_cmd || (count == '0);
  assign sts.scan_last = (idx == count - CW'(1));
  assign sts.out_free  = !out_valid || results.ready;

  // scan read, one slot a cycle
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) rd_data <= mem[idx[AW-1:0]];
    rd_idx <= idx[AW-1:0];
    if (wr_en) mem[wr_addr] <= {row_q, col_q, val_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      idx      <= '0;
    end else begin
      rd_valid <= cmd.scan_rd;
      if (cmd.scan_start) idx <= '0;
      else if (cmd.scan_rd) idx <= idx + CW'(1);
    end
  end

  // compare the slot read in the previous cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (cmd.scan_start) begin
      hit <= 1'b0;
    end else if (rd_valid && rd_data[63:48] == row_q && rd_data[47:32] == col_q) begin
      hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      acc <= 32'd0;
    end else if (rd_valid && rd_data[63:48] == row_q) begin
      acc <= acc + rd_data[31:0];
    end
    if (rd_valid && rd_data[63:48] == row_q && rd_data[47:32] == col_q) begin
      hit_idx <= rd_idx;
      hit_val <= rd_data[31:0];
    end
  end

  // write decision and result at the end of the command
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = hit_idx;
    count_next = count;
    fin_status = pre_status;
    fin_value  = 32'd0;
    if (pre_status == smct_pkg::STAT_OK) begin
      case (cmd_q)
        smct_pkg::CMD_INSERT: begin
          if (hit) begin
            wr_en = cmd.finish;
          end else if (count < Cap) begin
            wr_en   = cmd.finish;
            wr_addr = count[AW-1:0];
            count_next = count + CW'(1);
          end else begin
            fin_status = smct_pkg::STAT_FULL;
          end
        end
        smct_pkg::CMD_LOOKUP:  fin_value = hit ? hit_val : 32'd0;
        smct_pkg::CMD_ROW_SUM: fin_value = acc;
        default:               fin_value = 32'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.finish) begin
      count <= count_next;
    end
  end

  assign count_ext = 32'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value  <= fin_value;
      out_count  <= count_ext[6:0];
      out_status <= fin_status;
    end
  end

  assign results.valid        = out_valid;
  assign results.result_value = $signed(out_value);
  assign results.entry_count  = out_count;
  assign results.status       = out_status;

  `SMCT_ASSERT(a_count_bound, count <= Cap, "entry count above capacity")
  `SMCT_ASSERT(a_scan_in_fill, !cmd.scan_rd || (idx < count), "scan read past filled slots")
  `SMCT_ASSERT_IMP(a_count_hold, !cmd.finish, $stable(count), "count moved outside finish")
  `SMCT_ASSERT_IMP(a_finish_loads, cmd.finish, out_valid, "finish did not load result")

endmodule

/* rtl/core/sparse_matrix_coo_table.sv */
// Sparse matrix coordinate table: holds up to CAPACITY nonzero (row, col, value) entries in a
// single-port entry memory filled in slot order. One command is worked at a time. Insert, lookup
// and row sum scan the filled slots one per cycle through the memory read port, so a command
// goes from its accept beat through evaluate, scan and drain to the loading of its result beat;
// a command rejected for range, a zero insert value, the unused code, or an empty table skips
// the scan and drain. Loading waits while the previous result beat is still held, and the next
// command beat is taken at the earliest in the cycle after loading, while a result beat still
// waits in the output register. Configuration writes must come only between commands; the
// block itself does not enforce this.
module sparse_matrix_coo_table #(
  parameter int CAPACITY = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [smct_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [smct_pkg::CfgDataW-1:0]  cfg_data,
  smct_in_if.sink                        items,
  smct_out_if.source                     results
);

  smct_pkg::ctrl_cmd_t    cmd;
  smct_pkg::ctrl_status_t sts;

  smct_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  smct_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items),
    .results   (results),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* bench/coo_table_checker.sv */
// result checker for the coordinate table: tracks the table, predicts each result beat, compares
`timescale 1ns / 100ps

module coo_table_checker #(
  parameter int CAPACITY = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [smct_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [smct_pkg::CfgDataW-1:0]  cfg_data,
  smct_in_if                             items,
  smct_out_if                            results,
  output int unsigned                    mismatches,
  output int unsigned                    outstanding,
  output int unsigned                    results_seen
);

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [6:0]         entry_count;
    smct_pkg::status_t  status;
  } table_result_t;

  logic [15:0]   dim_rows;
  logic [15:0]   dim_cols;
  bit            slot_used [CAPACITY];
  logic [15:0]   slot_row  [CAPACITY];
  logic [15:0]   slot_col  [CAPACITY];
  logic [31:0]   slot_value[CAPACITY];
  int unsigned   entries_stored;
  table_result_t pending_results[$];

  function automatic int find_entry(input logic [15:0] r, input logic [15:0] c);
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot_used[i] && slot_row[i] == r && slot_col[i] == c) return i;
    end
    return -1;
  endfunction

  // applies one command to the tracked table and returns the result it causes
  function automatic table_result_t table_step(input logic [1:0] cmd, input logic [15:0] r,
                                               input logic [15:0] c, input logic [31:0] v);
    table_result_t res;
    bit            row_in;
    bit            col_in;
    int            hit;
    logic [31:0]   sum;
    res.result_value = '0;
    res.status       = smct_pkg::STAT_OK;
    row_in = (r >= 16'd1) && (r <= dim_rows);
    col_in = (c >= 16'd1) && (c <= dim_cols);
    sum    = '0;
    case (cmd)
      smct_pkg::CMD_INSERT: begin
        if (!row_in || !col_in) begin
          res.status = smct_pkg::STAT_RANGE;
        end else if (v == 32'd0) begin
          res.status = smct_pkg::STAT_ZERO;
        end else begin
          hit = find_entry(r, c);
          if (hit >= 0) begin
            slot_value[hit] = v;
          end else if (entries_stored < CAPACITY) begin
            // slots are never freed, so the next free one is at the count
            slot_used[entries_stored]  = 1'b1;
            slot_row[entries_stored]   = r;
            slot_col[entries_stored]   = c;
            slot_value[entries_stored] = v;
            entries_stored++;
          end else begin
            res.status = smct_pkg::STAT_FULL;
          end
        end
      end
      smct_pkg::CMD_LOOKUP: begin
        if (!row_in || !col_in) begin
          res.status = smct_pkg::STAT_RANGE;
        end else begin
          hit = find_entry(r, c);
          if (hit >= 0) res.result_value = slot_value[hit];
        end
      end
      smct_pkg::CMD_ROW_SUM: begin
        if (!row_in) begin
          res.status = smct_pkg::STAT_RANGE;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (slot_used[i] && slot_row[i] == r) sum += slot_value[i];
          end
          res.result_value = sum;
        end
      end
      default: ;
    endcase
    res.entry_count = entries_stored[6:0];
    return res;
  endfunction

  always @(posedge clk) begin
    table_result_t got;
    table_result_t want;
    if (rst) begin
      dim_rows       = 16'd1;
      dim_cols       = 16'd1;
      entries_stored = 0;
      for (int i = 0; i < CAPACITY; i++) slot_used[i] = 1'b0;
      pending_results.delete();
      mismatches   <= 0;
      outstanding  <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          smct_pkg::CFG_NUM_ROWS: dim_rows = cfg_data;
          smct_pkg::CFG_NUM_COLS: dim_cols = cfg_data;
          default: ;
        endcase
      end
      // check the result beat before queueing the new command
      if (results.valid && results.ready) begin
        got.result_value = results.result_value;
        got.entry_count  = results.entry_count;
        got.status       = smct_pkg::status_t'(results.status);
        results_seen <= results_seen + 1;
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("error: result beat with nothing expected: value %0d count %0d status %0d",
                     got.result_value, got.entry_count, got.status);
          mismatches <= mismatches + 1;
        end else begin
          want = pending_results.pop_front();
          if (got.result_value !== want.result_value || got.entry_count !== want.entry_count ||
              got.status !== want.status) begin
            if (mismatches < 10)
              $display("error: result %0d expected value %0d count %0d status %0d, got %0d %0d %0d",
                       results_seen, want.result_value, want.entry_count, want.status,
                       got.result_value, got.entry_count, got.status);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (items.valid && items.ready)
        pending_results.push_back(table_step(items.command, items.row, items.col, items.value));
      outstanding <= pending_results.size();
    end
  end

endmodule

/* bench/testbench.sv */
// top of the coordinate table bench: clock, reset, command stimulus, register writes, verdict
`timescale 1ns / 100ps

module testbench;

  localparam int         CAPACITY   = 64;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [smct_pkg::CfgIndexW-1:0] cfg_index;
  logic [smct_pkg::CfgDataW-1:0]  cfg_data;

  smct_in_if  items_ch ();
  smct_out_if results_ch ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_seen;
  int unsigned sent_count;
  int unsigned cfg_writes;
  int unsigned sender_idle_pct;
  int unsigned recv_idle_pct;
  logic [15:0] cur_rows;
  logic [15:0] cur_cols;
  logic        hold_off;

  sparse_matrix_coo_table #(.CAPACITY(CAPACITY)) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .items    (items_ch),
    .results  (results_ch)
  );

  coo_table_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .items       (items_ch),
    .results     (results_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .results_seen(results_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      results_ch.ready <= 1'b0;
    end else begin
      results_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver stall so the table backs up and drops its input ready
  initial begin
    hold_off <= 1'b0;
    @(posedge clk);
    while (sent_count < 120) @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_item(input logic [1:0] cmd, input logic [15:0] r, input logic [15:0] c,
                           input logic [31:0] v);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      items_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_ch.valid   <= 1'b1;
    items_ch.command <= cmd;
    items_ch.row     <= r;
    items_ch.col     <= c;
    items_ch.value   <= v;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    sent_count <= sent_count + 1;
  endtask

  // lowers valid and waits until every result beat is back
  task automatic wait_idle();
    items_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_dims(input logic [15:0] rows, input logic [15:0] cols);
    cfg_we    <= 1'b1;
    cfg_index <= smct_pkg::CFG_NUM_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_index <= smct_pkg::CFG_NUM_COLS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_rows   = rows;
    cur_cols   = cols;
    cfg_writes += 2;
  endtask

  // mostly inside the hot span, with edges just outside and some full-range noise
  function automatic logic [15:0] pick_coord(input int unsigned span, input logic [15:0] limit);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return 16'd0;
    if (roll < 10) return limit + 16'd1;
    if (roll < 14) return 16'($urandom);
    return 16'($urandom_range(span, 1));
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) return 32'd0;
    if (roll < 12) return 32'h7fff_ffff;
    if (roll < 16) return 32'h8000_0000;
    if (roll < 20) return 32'hffff_ffff;
    return $urandom;
  endfunction

  task automatic random_items(input int unsigned count, input int unsigned row_span,
                              input int unsigned col_span);
    int unsigned roll;
    logic [1:0]  cmd;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 45) cmd = smct_pkg::CMD_INSERT;
      else if (roll < 78) cmd = smct_pkg::CMD_LOOKUP;
      else if (roll < 95) cmd = smct_pkg::CMD_ROW_SUM;
      else cmd = CMD_UNUSED;
      send_item(cmd, pick_coord(row_span, cur_rows), pick_coord(col_span, cur_cols),
                pick_value());
    end
  endtask

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    items_ch.valid   <= 1'b0;
    items_ch.command <= '0;
    items_ch.row     <= '0;
    items_ch.col     <= '0;
    items_ch.value   <= '0;
    sent_count       <= 0;
    cfg_writes       = 0;
    sender_idle_pct  <= 30;
    recv_idle_pct    <= 63;
    cur_rows         = 16'd1;
    cur_cols         = 16'd1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset dimensions are 1 x 1
    send_item(smct_pkg::CMD_INSERT, 16'd1, 16'd1, 32'd5);
    send_item(smct_pkg::CMD_LOOKUP, 16'd1, 16'd1, 32'd0);
    send_item(smct_pkg::CMD_INSERT, 16'd2, 16'd1, 32'd7);
    send_item(smct_pkg::CMD_INSERT, 16'd1, 16'd0, 32'd7);
    send_item(smct_pkg::CMD_LOOKUP, 16'd0, 16'd1, 32'd0);
    send_item(smct_pkg::CMD_INSERT, 16'd1, 16'd1, 32'd0);
    send_item(smct_pkg::CMD_LOOKUP, 16'd1, 16'd1, 32'd0);
    send_item(smct_pkg::CMD_ROW_SUM, 16'd1, 16'd1, 32'd0);
    send_item(smct_pkg::CMD_ROW_SUM, 16'd2, 16'd1, 32'd0);
    send_item(CMD_UNUSED, 16'hffff, 16'hffff, 32'hffff_ffff);
    send_item(smct_pkg::CMD_INSERT, 16'd1, 16'd1, 32'hffff_fff7);
    send_item(smct_pkg::CMD_INSERT, 16'd0, 16'd0, 32'd0);
    wait_idle();
    set_dims(16'hffff, 16'hffff);
    send_item(smct_pkg::CMD_INSERT, 16'hffff, 16'hffff, 32'h7fff_ffff);
    send_item(smct_pkg::CMD_INSERT, 16'hffff, 16'd1, 32'h8000_0000);
    send_item(smct_pkg::CMD_ROW_SUM, 16'hffff, 16'd0, 32'd0);
    send_item(smct_pkg::CMD_LOOKUP, 16'hffff, 16'hffff, 32'd0);
    send_item(smct_pkg::CMD_LOOKUP, 16'hfffe, 16'hffff, 32'd0);
    send_item(smct_pkg::CMD_INSERT, 16'd0, 16'hffff, 32'd1);
    send_item(smct_pkg::CMD_INSERT, 16'hffff, 16'hffff, 32'hffff_ffff);
    send_item(smct_pkg::CMD_ROW_SUM, 16'd0, 16'd1, 32'd0);
    send_item(smct_pkg::CMD_LOOKUP, 16'd1, 16'd1, 32'd0);
    send_item(smct_pkg::CMD_INSERT, 16'd1, 16'hffff, 32'd0);
    wait_idle();
    // shrink: stored entries stay counted but drop out of reach
    set_dims(16'd1, 16'd1);
    send_item(smct_pkg::CMD_LOOKUP, 16'hffff, 16'hffff, 32'd0);
    send_item(smct_pkg::CMD_ROW_SUM, 16'hffff, 16'd1, 32'd0);
    wait_idle();

    set_dims(16'd4, 16'd4);
    random_items(300, 4, 4);
    wait_idle();

    sender_idle_pct <= 63;
    recv_idle_pct   <= 30;
    set_dims(16'd8, 16'hffff);
    random_items(300, 8, 12);
    wait_idle();

    sender_idle_pct <= 0;
    recv_idle_pct   <= 0;
    set_dims(16'd1, 16'd1);
    random_items(120, 1, 1);
    wait_idle();

    // distinct positions so the table is sure to fill and reject new inserts
    set_dims(16'hffff, 16'hffff);
    for (int k = 0; k < CAPACITY + 6; k++)
      send_item(smct_pkg::CMD_INSERT, 16'(1000 + k), 16'(k + 1), $urandom | 32'd1);
    random_items(240, 16, 16);
    wait_idle();
    repeat (CAPACITY + 8) @(posedge clk);

    $display("summary: %0d commands sent, %0d result beats checked, %0d register writes",
             sent_count, results_seen, cfg_writes);
    $display("summary: dims from 1x1 to 65535x65535, replace, zero reject, full table, shrink");
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/smct_pkg.sv
rtl/core/smct_if.sv
rtl/core/smct_ctrl.sv
rtl/core/smct_datapath.sv
rtl/core/sparse_matrix_coo_table.sv
bench/coo_table_checker.sv
bench/testbench.sv
